// ===== rtl/core/gcra_pkg.sv =====
package gcra_pkg;
  localparam int ROW_W = 32;
  localparam int IDX_W = 5;
  localparam int COL_W = 2;
  localparam int CNT_W = 3;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SIMP,
    ST_SEL,
    ST_EMIT,
    ST_SPILL
  } state_t;

  typedef struct packed {
    logic load_row;
    logic start;
    logic simp_step;
    logic sel_step;
    logic emit_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic simp_done;
    logic simp_fail;
    logic sel_done;
    logic sel_fail;
    logic emit_last;
  } stat_t;
endpackage

// ===== rtl/core/gcra_if.sv =====
interface gcra_in_if;
  logic                      valid;
  logic                      ready;
  logic [gcra_pkg::ROW_W-1:0] adjacency_row;
  logic                      final_row;
  modport source (output valid, adjacency_row, final_row, input ready);
  modport sink (input valid, adjacency_row, final_row, output ready);
endinterface

interface gcra_out_if;
  logic                       valid;
  logic                       ready;
  logic [gcra_pkg::IDX_W-1:0] vertex_index;
  logic [gcra_pkg::COL_W-1:0] color;
  logic                       spill;
  logic                       last_result;
  modport source (output valid, vertex_index, color, spill, last_result, input ready);
  modport sink (input valid, vertex_index, color, spill, last_result, output ready);
endinterface

interface gcra_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gcra_pkg::CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/gcra_ctrl.sv =====
module gcra_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             in_final,
  input  logic             out_ready,
  input  gcra_pkg::stat_t  stat,
  output gcra_pkg::cmd_t   cmd,
  output gcra_pkg::state_t state
);
  import gcra_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_fire && in_final) state_nxt = ST_SIMP;
      ST_SIMP: begin
        if (stat.simp_fail) state_nxt = ST_SPILL;
        else if (stat.simp_done) state_nxt = ST_SEL;
      end
      ST_SEL: begin
        if (stat.sel_fail) state_nxt = ST_SPILL;
        else if (stat.sel_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: if (out_ready && stat.emit_last) state_nxt = ST_LOAD;
      ST_SPILL: if (out_ready) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load_row = in_fire;
        cmd.start    = in_fire && in_final;
      end
      ST_SIMP: cmd.simp_step = !stat.simp_done && !stat.simp_fail;
      ST_SEL: cmd.sel_step = !stat.sel_done && !stat.sel_fail;
      ST_EMIT: begin
        cmd.emit_step = out_ready;
        cmd.clear     = out_ready && stat.emit_last;
      end
      ST_SPILL: cmd.clear = out_ready;
      default: cmd = '0;
    endcase
  end

  assign state = state_r;

`ifndef SYNTHESIS
  a_spill_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SPILL && out_ready) |=> state_r == ST_LOAD)
    else $error("spill did not return to load");
  a_start_simp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && in_fire && in_final) |=> state_r == ST_SIMP)
    else $error("final row did not start simplify");
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_ready) |=> state_r == ST_EMIT)
    else $error("emit left while stalled");
`endif
endmodule

// ===== rtl/core/gcra_dp.sv =====
module gcra_dp #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_COLORS   = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gcra_pkg::cmd_t             cmd,
  input  logic [gcra_pkg::ROW_W-1:0] row_in,
  input  logic [gcra_pkg::CNT_W-1:0] color_count,
  output gcra_pkg::stat_t            stat,
  output logic [gcra_pkg::IDX_W-1:0] emit_idx,
  output logic [gcra_pkg::COL_W-1:0] emit_col
);
  import gcra_pkg::*;

  localparam int NV = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int VW = $clog2(NV);
  localparam int NW = $clog2(NV + 1);
  localparam int KC = (MAX_COLORS < 4) ? MAX_COLORS : 4;
  localparam int DW = $clog2(ROW_W + 1);

  logic [ROW_W-1:0] adj_r [NV];
  logic [VW-1:0]    stk_r [NV];
  logic [COL_W-1:0] col_r [NV];
  logic [NW-1:0]    n_r, sp_r, scan_r;
  logic [NV-1:0]    removed_r, colored_r, vmask;
  logic [CNT_W-1:0] k_r;
  logic [VW-1:0]    emit_r;

  always_comb begin
    for (int i = 0; i < NV; i++) vmask[i] = (i < int'(n_r));
  end

  // simplify: one candidate vertex examined per cycle
  logic [NW-1:0] best_deg_r;
  logic          best_ok_r;
  logic [VW-1:0] best_v_r;
  logic [VW-1:0] scan_v;
  logic [NV-1:0] nb_s;
  logic [DW-1:0] deg;
  logic          cand;

  assign scan_v = scan_r[VW-1:0];
  always_comb begin
    nb_s = adj_r[scan_v][NV-1:0] & vmask & ~removed_r;
    nb_s[scan_v] = 1'b0;
    deg = DW'($countones(nb_s));
    cand = !removed_r[scan_v] && (deg < DW'(k_r)) &&
           (!best_ok_r || deg > DW'(best_deg_r));
  end

  // select: pop one vertex per cycle
  logic [VW-1:0]  pv;
  logic [NV-1:0]  nb_c;
  logic [KC-1:0]  used;
  logic           found;
  logic [COL_W-1:0] pick_c;

  assign pv = stk_r[sp_r[VW-1:0] - VW'(1)];
  always_comb begin
    nb_c = adj_r[pv][NV-1:0] & vmask & colored_r;
    nb_c[pv] = 1'b0;
    used = '0;
    for (int i = 0; i < NV; i++)
      if (nb_c[i]) used |= KC'(1) << col_r[i];
    found = 1'b0;
    pick_c = '0;
    for (int c = KC - 1; c >= 0; c--)
      if (c < int'(k_r) && !used[c]) begin
        found = 1'b1;
        pick_c = COL_W'(c);
      end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
      sp_r <= '0;
      scan_r <= '0;
      removed_r <= '0;
      colored_r <= '0;
      best_ok_r <= 1'b0;
      emit_r <= '0;
    end else begin
      if (cmd.load_row && n_r < NW'(NV)) begin
        adj_r[n_r[VW-1:0]] <= row_in;
        n_r <= n_r + NW'(1);
      end
      if (cmd.start) begin
        k_r <= (color_count > CNT_W'(KC)) ? CNT_W'(KC) : color_count;
        scan_r <= '0;
        sp_r <= '0;
        removed_r <= '0;
        colored_r <= '0;
        best_ok_r <= 1'b0;
        emit_r <= '0;
      end
      if (cmd.simp_step) begin
        if (scan_r == n_r - NW'(1)) begin
          scan_r <= '0;
          best_ok_r <= 1'b0;
          if (cand || best_ok_r) begin
            stk_r[sp_r[VW-1:0]] <= cand ? scan_v : best_v_r;
            removed_r[cand ? scan_v : best_v_r] <= 1'b1;
            sp_r <= sp_r + NW'(1);
          end
        end else begin
          scan_r <= scan_r + NW'(1);
          if (cand) begin
            best_ok_r <= 1'b1;
            best_deg_r <= NW'(deg);
            best_v_r <= scan_v;
          end
        end
      end
      if (cmd.sel_step && found) begin
        col_r[pv] <= pick_c;
        colored_r[pv] <= 1'b1;
        sp_r <= sp_r - NW'(1);
      end
      if (cmd.emit_step) emit_r <= emit_r + VW'(1);
      if (cmd.clear) begin
        n_r <= '0;
        sp_r <= '0;
        removed_r <= '0;
      end
    end
  end

  assign stat.simp_done = (sp_r == n_r);
  assign stat.simp_fail = (sp_r != n_r) && (scan_r == n_r - NW'(1)) && !cand && !best_ok_r;
  assign stat.sel_done  = (sp_r == '0);
  assign stat.sel_fail  = (sp_r != '0) && !found;
  assign stat.emit_last = ({1'b0, emit_r} == n_r - NW'(1));
  assign emit_idx = IDX_W'(emit_r);
  assign emit_col = col_r[emit_r];

`ifndef SYNTHESIS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= n_r)
    else $error("stack deeper than vertex count");
  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(NV))
    else $error("row count overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sel_step && found) |=> colored_r[$past(pv)])
    else $error("popped vertex not colored");
`endif
endmodule

// ===== rtl/core/graph_coloring_register_allocator_core.sv =====
// Chaitin graph coloring allocator. Adjacency rows load one per cycle; the final row
// starts allocation and input stalls until results are taken. Simplify scans one vertex
// per cycle; select pops one vertex per cycle; then n results stream out, one per cycle
// while the receiver is ready, or a single spill result.
module graph_coloring_register_allocator_core #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_COLORS   = 4
) (
  input logic clk,
  input logic rst_n,
  gcra_in_if.sink    in_ch,
  gcra_out_if.source out_ch,
  gcra_cfg_if.sink   cfg_ch
);
  import gcra_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  state_t           state;
  logic [CNT_W-1:0] color_count_r;
  logic [IDX_W-1:0] emit_idx;
  logic [COL_W-1:0] emit_col;
  logic             in_fire;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= CNT_W'(4);
    end else if (cfg_ch.valid) begin
      color_count_r <= cfg_ch.data;
    end
  end

  assign in_ch.ready = (state == ST_LOAD);
  assign in_fire = in_ch.valid && in_ch.ready;

  gcra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_final(in_ch.final_row),
    .out_ready(out_ch.ready), .stat(stat), .cmd(cmd), .state(state)
  );

  gcra_dp #(.MAX_VERTICES(MAX_VERTICES), .MAX_COLORS(MAX_COLORS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .row_in(in_ch.adjacency_row),
    .color_count(color_count_r), .stat(stat), .emit_idx(emit_idx), .emit_col(emit_col)
  );

  always_comb begin
    out_ch.valid        = (state == ST_EMIT) || (state == ST_SPILL);
    out_ch.spill        = (state == ST_SPILL);
    out_ch.vertex_index = (state == ST_EMIT) ? emit_idx : '0;
    out_ch.color        = (state == ST_EMIT) ? emit_col : '0;
    out_ch.last_result  = (state == ST_SPILL) || stat.emit_last;
  end
endmodule

// ===== dv/gcra_tb_pkg.sv =====
package gcra_tb_pkg;
  import gcra_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic [COL_W-1:0] color;
    logic             spill;
    logic             last_result;
  } alloc_t;

  class alloc_scoreboard;
    logic [ROW_W-1:0] graph[32];
    int               rows_held;
    int               colors;
    alloc_t           pending[$];
    int               mismatches;

    function void clear();
      rows_held = 0;
      colors = 4;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_colors(logic [CNT_W-1:0] value);
      colors = value;
    endfunction

    function void spill_out();
      alloc_t r;
      r = '0;
      r.spill = 1'b1;
      r.last_result = 1'b1;
      pending.push_back(r);
    endfunction

    function void color_graph();
      int n, k, left, pick, best, deg, v, c, depth;
      logic [31:0] vmask, gone, colored, nb;
      logic [3:0] used;
      int order[32];
      int hue[32];
      alloc_t r;
      n = rows_held;
      k = colors > 4 ? 4 : colors;
      vmask = n >= 32 ? '1 : (32'd1 << n) - 1;
      gone = '0;
      colored = '0;
      depth = 0;
      for (v = 0; v < 32; v++) hue[v] = 0;
      for (left = n; left > 0; left--) begin
        pick = -1;
        best = -1;
        for (v = 0; v < n; v++) begin
          if (!gone[v]) begin
            deg = $countones(graph[v] & vmask & ~gone & ~(32'd1 << v));
            if (deg < k && deg > best) begin
              best = deg;
              pick = v;
            end
          end
        end
        if (pick < 0) begin
          spill_out();
          return;
        end
        order[depth++] = pick;
        gone[pick] = 1'b1;
      end
      while (depth > 0) begin
        v = order[--depth];
        nb = graph[v] & vmask & ~(32'd1 << v) & colored;
        used = '0;
        for (c = 0; c < n; c++) if (nb[c]) used[hue[c]] = 1'b1;
        for (c = 0; c < k; c++) if (!used[c]) break;
        if (c >= k) begin
          spill_out();
          return;
        end
        hue[v] = c;
        colored[v] = 1'b1;
      end
      for (v = 0; v < n; v++) begin
        r.vertex_index = v[IDX_W-1:0];
        r.color = hue[v][COL_W-1:0];
        r.spill = 1'b0;
        r.last_result = (v == n - 1);
        pending.push_back(r);
      end
    endfunction

    function void note_row(logic [ROW_W-1:0] row, logic fin);
      if (rows_held < 32) graph[rows_held++] = row;
      if (fin) begin
        color_graph();
        rows_held = 0;
      end
    endfunction

    function void check_result(alloc_t got);
      alloc_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass
endpackage

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gcra_pkg::*;
  import gcra_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int hold_off = 0;
  alloc_scoreboard sb;

  gcra_in_if in_ch();
  gcra_out_if out_ch();
  gcra_cfg_if cfg_ch();

  graph_coloring_register_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  task automatic send_row(logic [ROW_W-1:0] row, logic fin, bit gaps = 1);
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      idle_cycles(gap_len());
    end
    in_ch.valid <= 1'b1;
    in_ch.adjacency_row <= row;
    in_ch.final_row <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_row(row, fin);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    idle_cycles(40);
  endtask

  task automatic write_colors(logic [CNT_W-1:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_colors(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [ROW_W-1:0] rand_row(int dens);
    logic [ROW_W-1:0] r;
    r = '0;
    for (int j = 0; j < 32; j++) if ($urandom_range(0, 99) < dens) r[j] = 1'b1;
    return r;
  endfunction

  task automatic send_graph(int n, int dens);
    for (int i = 0; i < n; i++) send_row(rand_row(dens), i == n - 1);
  endtask

  task automatic g_send();
    int n;
    n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 6);
    if ($urandom_range(0, 9) == 0) n = 1;
    send_graph(n, n > 8 ? 6 : $urandom_range(5, 60));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.vertex_index, out_ch.color, out_ch.spill,
                        out_ch.last_result});
  end

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        g = gap_len();
        if (g > 0) idle_cycles(g - 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #50ms;
    $display("graph_coloring_register_allocator_core test failed");
    $finish;
  end

  initial begin
    sb = new();
    sb.clear();
    in_ch.valid = 1'b0;
    in_ch.adjacency_row = '0;
    in_ch.final_row = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, empty graph, clique spill, over-capacity rows
    send_row('1, 1'b1);
    send_row('0, 1'b0);
    send_row('0, 1'b1);
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b0);
    send_row(32'hFFFF_FFFF, 1'b1);
    send_row(32'h0000_0002, 1'b0);
    send_row(32'h0000_0001, 1'b1);
    write_colors(3'd1);
    send_row(32'h2, 1'b0);
    send_row(32'h1, 1'b1);
    send_row(32'h5555_AAAA, 1'b1);
    write_colors(3'd0);
    send_row(32'h0, 1'b1);
    write_colors(3'd7);
    for (int i = 0; i < 34; i++) send_row(i[0] ? 32'hAAAA_AAAA : 32'h5555_5555, i == 33);

    // pressure: long receiver hold-off while rows keep coming
    hold_off = 300;
    send_graph(4, 20);
    send_graph(3, 10);

    for (int ph = 0; ph < 5; ph++) begin
      write_colors(ph == 4 ? 3'd4 : 3'($urandom_range(1, 6)));
      for (int c = 0; c < 10; c++) begin
        g_send();
      end
    end
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("graph_coloring_register_allocator_core test passed");
    else
      $display("graph_coloring_register_allocator_core test failed");
    $finish;
  end
endmodule
